// ===== hdl/scba_pkg.sv =====
// Shared types and constants for the size-class bump allocator.
// Field widths, stream packing and result codes; no dependencies.
package scba_pkg;

  // Field widths of one request and one result
  localparam int RAW_W      = 24;  // req_size before rounding
  localparam int SIZE_W     = 25;  // rounded size, up to 2^24
  localparam int OFF_W      = 32;  // free_offset and alloc_offset
  localparam int IN_DATA_W  = 56;  // req_size, free_offset
  localparam int IN_USER_W  = 1;   // cmd
  localparam int OUT_DATA_W = 40;  // alloc_offset, outcome, zero pad
  localparam int OC_W       = 3;

  // Allocation granule
  localparam logic [SIZE_W-1:0] GRAIN_M1 = SIZE_W'(15);
  localparam logic [SIZE_W-1:0] GRAIN    = SIZE_W'(16);
  localparam int GRAIN_SH = 4;

  // Request kinds carried in tuser
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result codes
  typedef enum logic [OC_W-1:0] {
    OC_BUMP    = 3'd0,
    OC_REUSE   = 3'd1,
    OC_FAIL    = 3'd2,
    OC_SHRINK  = 3'd3,
    OC_LISTED  = 3'd4,
    OC_DROPPED = 3'd5
  } outcome_t;

endpackage

// ===== hdl/scba_cnt_mem.sv =====
// Per-class fill counts of the free lists, one synchronous read port.
// Valid bits cleared by reset make every count read as zero until written.
module scba_cnt_mem #(
  parameter int NUM_CLASSES = 16,
  parameter int CW          = 4,
  parameter int CNT_W       = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             rd_en,
  input  logic [CW-1:0]    rd_addr,
  output logic [CNT_W-1:0] rd_cnt,
  input  logic             wr_en,
  input  logic [CW-1:0]    wr_addr,
  input  logic [CNT_W-1:0] wr_cnt
);

  logic [CNT_W-1:0] mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] vld_r;
  logic [CNT_W-1:0] q_r;
  logic             qv_r;

  // Track which counts have been written since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      qv_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        qv_r <= vld_r[rd_addr];
      end
    end
  end

  // Storage and registered read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_cnt;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_cnt = qv_r ? q_r : '0;

endmodule

// ===== hdl/scba_ent_mem.sv =====
// Free-list entries of all classes in one synchronous memory.
// Class c, slot s lives at c*LIST_DEPTH+s; unwritten entries are never read.
module scba_ent_mem #(
  parameter int DEPTH = 240,
  parameter int EA_W  = 8,
  parameter int AW    = 32
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [EA_W-1:0] rd_addr,
  output logic [AW-1:0]   rd_data,
  input  logic            wr_en,
  input  logic [EA_W-1:0] wr_addr,
  input  logic [AW-1:0]   wr_data
);

  logic [AW-1:0] mem [DEPTH];
  logic [AW-1:0] q_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      q_r <= mem[rd_addr];
    end
  end

  assign rd_data = q_r;

endmodule

// ===== hdl/scba_rem.sv =====
// Remainder of the heap overshoot by the constant chunk size.
// Reciprocal multiplication over three pipeline stages; no dependencies.
module scba_rem #(
  parameter int DIV_W       = 25,
  parameter int CHUNK_BYTES = 16384,
  parameter int RW          = 15
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  output logic             done,
  output logic [RW-1:0]    rem
);

  // Reciprocal of the chunk size, exact for every dividend below 2^DIV_W
  localparam int CB = $clog2(CHUNK_BYTES);
  localparam int SH = DIV_W + CB;
  localparam int MW = DIV_W + 1;
  localparam int PW = DIV_W + MW;
  localparam int QW = DIV_W + 1 - CB;
  localparam logic [MW-1:0] RECIP =
    MW'(((64'd1 << SH) + 64'(CHUNK_BYTES) - 64'd1) / 64'(CHUNK_BYTES));
  localparam logic [DIV_W-1:0] CHK = DIV_W'(CHUNK_BYTES);

  logic             v1_r;
  logic             v2_r;
  logic             done_r;
  logic [DIV_W-1:0] x_r;
  logic [QW-1:0]    q_r;
  logic [RW-1:0]    rem_r;
  logic [PW-1:0]    prod;
  logic [DIV_W-1:0] back;

  // Quotient estimate and the multiple of the chunk it covers
  always_comb begin
    prod = PW'(x_r) * PW'(RECIP);
    back = DIV_W'(q_r) * CHK;
  end

  // Stage valids and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      v1_r   <= start;
      v2_r   <= v1_r;
      done_r <= v2_r;
    end
  end

  // Capture the dividend, then the quotient, then the remainder
  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= dividend;
    end
    if (v1_r) begin
      q_r <= QW'(prod >> SH);
    end
    if (v2_r) begin
      rem_r <= RW'(x_r - back);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== hdl/size_class_bump_allocator.sv =====
// Size-class bump allocator: top level with request control, bump pointer and heap end.
// Uses scba_pkg, scba_cnt_mem, scba_ent_mem and scba_rem.
//
// Each item is an allocate or free request; each gives exactly one result item.
// Sizes round up to 16 bytes. Small allocations first pop the LIFO list of
// their size class, otherwise the bump pointer advances and the heap end grows
// in whole chunks; growth past the heap limit fails with no state change.
// The accept cycle reads the class count memory and the next cycle decides.
// A list reuse adds a state for the entry memory read. An allocation that
// grows the heap waits on the chunk remainder, which comes from a three-stage
// reciprocal multiply. The overshoot past the heap end stays below the rounded
// size plus the header, so 25 bits carry it. A result that waits on out_tready
// holds back the finish of the next item.
// One item is in work at a time; a new item is taken while the previous result
// still waits in the output register. The count memory is cleared by valid
// bits at reset, so no clearing pass is needed; the heap limit register resets
// to all ones.
module size_class_bump_allocator #(
  parameter int NUM_CLASSES  = 16,
  parameter int LIST_DEPTH   = 15,
  parameter int CHUNK_BYTES  = 16384,
  parameter int HEADER_BYTES = 2064,
  parameter int ADDR_BITS    = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Request stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [scba_pkg::IN_DATA_W-1:0]   in_tdata,   // req_size[23:0], free_offset[55:24]
  input  logic [scba_pkg::IN_USER_W-1:0]   in_tuser,   // cmd[0]
  // Result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [scba_pkg::OUT_DATA_W-1:0]  out_tdata,  // alloc_offset[31:0], outcome[34:32]
  // Heap limit register write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [31:0]                      cfg_data
);

  import scba_pkg::*;

  localparam int AW    = ADDR_BITS;
  localparam int DW    = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 2;
  localparam int CW    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CNT_W = $clog2(LIST_DEPTH + 1);
  localparam int EDEP  = NUM_CLASSES * LIST_DEPTH;
  localparam int EA_W  = (EDEP > 1) ? $clog2(EDEP) : 1;
  localparam int RW    = $clog2(CHUNK_BYTES) + 1;
  localparam logic [EA_W-1:0]   LD_E    = EA_W'(LIST_DEPTH);
  localparam logic [CNT_W-1:0]  LD_C    = CNT_W'(LIST_DEPTH);
  localparam logic [SIZE_W-1:0] MAX_CLS = SIZE_W'(NUM_CLASSES * 16);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_POP  = 5'b00100,
    S_DIV  = 5'b01000,
    S_GROW = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  // Architectural state
  logic [AW-1:0] bump_r, bump_nxt;
  logic [DW-1:0] hend_r, hend_nxt;
  logic [31:0]   limit_r;

  // Request held through its work
  logic              cmd_r;
  logic [SIZE_W-1:0] size_r;
  logic [AW-1:0]     off_r;
  logic [CW-1:0]     cls_r;
  logic              has_r;
  logic [DW-1:0]     top_r, top_nxt;

  // Result register
  logic          out_valid_r;
  logic [31:0]   out_off_r, out_off_nxt;
  outcome_t      out_oc_r, out_oc_nxt;
  logic          fin;
  logic          out_free;

  // Incoming request decode
  logic              in_acc;
  logic [SIZE_W-1:0] size_in;
  logic [CW-1:0]     cls_in;
  logic              has_in;

  // Memory and remainder unit ports
  logic [CNT_W-1:0] cnt;
  logic             cnt_we;
  logic [CNT_W-1:0] cnt_wd;
  logic             ent_re;
  logic [EA_W-1:0]  ent_ra;
  logic [AW-1:0]    ent_q;
  logic             ent_we;
  logic [EA_W-1:0]  ent_wa;
  logic             rem_start;
  logic             rem_done;
  logic [RW-1:0]    rem;

  // Datapath terms
  logic [EA_W-1:0]  base;
  logic [DW-1:0]    top_w;
  logic             shrink;
  logic [DW-1:0]    new_end;
  logic             grow_fail;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid & in_tready;
  assign cfg_ready = 1'b1;
  assign out_free  = ~out_valid_r | out_tready;

  // Round the size up to the granule and find its class
  always_comb begin
    size_in = (SIZE_W'(in_tdata[RAW_W-1:0]) + GRAIN_M1) & ~GRAIN_M1;
    cls_in  = CW'((size_in >> GRAIN_SH) - SIZE_W'(1));
    has_in  = (size_in >= GRAIN) && (size_in <= MAX_CLS);
  end

  scba_cnt_mem #(
    .NUM_CLASSES (NUM_CLASSES),
    .CW          (CW),
    .CNT_W       (CNT_W)
  ) u_cnt (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc & has_in),
    .rd_addr (cls_in),
    .rd_cnt  (cnt),
    .wr_en   (cnt_we),
    .wr_addr (cls_r),
    .wr_cnt  (cnt_wd)
  );

  scba_ent_mem #(
    .DEPTH (EDEP),
    .EA_W  (EA_W),
    .AW    (AW)
  ) u_ent (
    .clk     (clk),
    .rd_en   (ent_re),
    .rd_addr (ent_ra),
    .rd_data (ent_q),
    .wr_en   (ent_we),
    .wr_addr (ent_wa),
    .wr_data (off_r)
  );

  scba_rem #(
    .DIV_W       (SIZE_W),
    .CHUNK_BYTES (CHUNK_BYTES),
    .RW          (RW)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (SIZE_W'(top_w - hend_r)),
    .done     (rem_done),
    .rem      (rem)
  );

  // Shared arithmetic of the decision and growth steps
  always_comb begin
    base      = EA_W'(cls_r) * LD_E;
    top_w     = DW'(bump_r) + DW'(size_r);
    shrink    = (DW'(off_r) + DW'(size_r)) == DW'(bump_r);
    new_end   = top_r - DW'(rem) + DW'(CHUNK_BYTES);
    grow_fail = (new_end > DW'(limit_r)) || ((new_end >> AW) != '0);
  end

  // Request sequencer
  always_comb begin
    state_nxt   = state_r;
    bump_nxt    = bump_r;
    hend_nxt    = hend_r;
    top_nxt     = top_r;
    out_off_nxt = out_off_r;
    out_oc_nxt  = out_oc_r;
    fin         = 1'b0;
    cnt_we      = 1'b0;
    cnt_wd      = cnt;
    ent_re      = 1'b0;
    ent_ra      = base + EA_W'(cnt - CNT_W'(1));
    ent_we      = 1'b0;
    ent_wa      = base + EA_W'(cnt);
    rem_start   = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (cmd_r == CMD_ALLOC) begin
          if (has_r && (cnt != '0)) begin
            // Pop the newest entry of the class list
            cnt_we    = 1'b1;
            cnt_wd    = cnt - CNT_W'(1);
            ent_re    = 1'b1;
            state_nxt = S_POP;
          end else if (top_w >= hend_r) begin
            // Heap must grow: work out the chunk remainder
            rem_start = 1'b1;
            top_nxt   = top_w;
            state_nxt = S_DIV;
          end else if (out_free) begin
            fin         = 1'b1;
            out_off_nxt = 32'(bump_r);
            out_oc_nxt  = OC_BUMP;
            bump_nxt    = AW'(top_w);
            state_nxt   = S_IDLE;
          end
        end else if (out_free) begin
          fin         = 1'b1;
          out_off_nxt = '0;
          state_nxt   = S_IDLE;
          if (shrink) begin
            bump_nxt   = off_r;
            out_oc_nxt = OC_SHRINK;
          end else if (has_r && (cnt < LD_C)) begin
            ent_we     = 1'b1;
            cnt_we     = 1'b1;
            cnt_wd     = cnt + CNT_W'(1);
            out_oc_nxt = OC_LISTED;
          end else begin
            out_oc_nxt = OC_DROPPED;
          end
        end
      end
      S_POP: begin
        if (out_free) begin
          fin         = 1'b1;
          out_off_nxt = 32'(ent_q);
          out_oc_nxt  = OC_REUSE;
          state_nxt   = S_IDLE;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        if (out_free) begin
          fin       = 1'b1;
          state_nxt = S_IDLE;
          if (grow_fail) begin
            out_off_nxt = '0;
            out_oc_nxt  = OC_FAIL;
          end else begin
            hend_nxt    = new_end;
            bump_nxt    = AW'(top_r);
            out_off_nxt = 32'(bump_r);
            out_oc_nxt  = OC_BUMP;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state, allocator state and heap limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bump_r      <= AW'(HEADER_BYTES);
      hend_r      <= DW'(CHUNK_BYTES);
      limit_r     <= 32'hFFFF_FFFF;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      bump_r  <= bump_nxt;
      hend_r  <= hend_nxt;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_data;
      end
      if (fin) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the request and hold the result payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r  <= in_tuser[0];
      size_r <= size_in;
      off_r  <= AW'(in_tdata[RAW_W +: OFF_W]);
      cls_r  <= cls_in;
      has_r  <= has_in;
    end
    top_r     <= top_nxt;
    out_off_r <= out_off_nxt;
    out_oc_r  <= out_oc_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_DATA_W - OC_W - 32)'(0), out_oc_r, out_off_r};

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps
// Testbench for size_class_bump_allocator: directed and random request streams
// checked item by item against a behavioral allocator model. Depends on scba_pkg.
module tb;
  import scba_pkg::*;

  localparam int NUM_CLASSES  = 16;
  localparam int LIST_DEPTH   = 15;
  localparam int CHUNK_BYTES  = 16384;
  localparam int HEADER_BYTES = 2064;
  localparam int ADDR_BITS    = 32;
  localparam int GRAIN_BYTES  = 16;
  localparam logic [63:0] ADDR_MASK = (64'd1 << ADDR_BITS) - 64'd1;
  localparam int QUIET_LIMIT  = 5000;
  localparam int TAIL_CYCLES  = 60;

  typedef struct {
    logic [31:0] offset;
    outcome_t    oc;
  } grant_t;

  typedef struct {
    logic [31:0] base;
    logic [24:0] span;
  } block_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic [IN_USER_W-1:0]  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [31:0]           cfg_data;

  // Allocator model state
  logic [63:0] mdl_bump;
  logic [63:0] mdl_end;
  logic [31:0] mdl_limit;
  int          mdl_count [NUM_CLASSES];
  logic [31:0] mdl_slot [NUM_CLASSES][LIST_DEPTH];

  grant_t   pending_grants[$];
  block_t   live_blocks[$];
  grant_t   seen_grant;
  outcome_t last_outcome;
  int       errors;
  int       quiet_cycles;
  int       stall_left;
  bit       no_idle;

  size_class_bump_allocator #(
    .NUM_CLASSES (NUM_CLASSES),
    .LIST_DEPTH  (LIST_DEPTH),
    .CHUNK_BYTES (CHUNK_BYTES),
    .HEADER_BYTES(HEADER_BYTES),
    .ADDR_BITS   (ADDR_BITS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Compute the result of one request and advance the model state
  function automatic grant_t predict_grant(logic cmd, logic [23:0] raw, logic [31:0] off);
    logic [63:0] size;
    logic [63:0] top;
    logic [63:0] new_end;
    logic [63:0] off64;
    int          cls;
    grant_t      g;
    size  = ({40'd0, raw} + 64'd15) & ~64'd15;
    off64 = {32'd0, off} & ADDR_MASK;
    if (size < 64'(GRAIN_BYTES) || size > 64'(NUM_CLASSES * GRAIN_BYTES)) cls = -1;
    else cls = int'(size / 64'(GRAIN_BYTES)) - 1;
    g.offset = 32'd0;
    if (cmd == CMD_ALLOC) begin
      if (cls >= 0 && mdl_count[cls] > 0) begin
        mdl_count[cls]--;
        g.offset = mdl_slot[cls][mdl_count[cls]];
        g.oc     = OC_REUSE;
        return g;
      end
      top     = mdl_bump + size;
      new_end = mdl_end;
      if (top >= mdl_end) begin
        new_end = mdl_end + ((top - mdl_end) / 64'(CHUNK_BYTES) + 64'd1) * 64'(CHUNK_BYTES);
        if (new_end > {32'd0, mdl_limit} || new_end > ADDR_MASK) begin
          g.oc = OC_FAIL;
          return g;
        end
      end
      mdl_end  = new_end;
      g.offset = mdl_bump[31:0];
      mdl_bump = top & ADDR_MASK;
      g.oc     = OC_BUMP;
      return g;
    end
    // Free: shrink if the block ends at the pointer, else list or drop it
    if (off64 + size == mdl_bump) begin
      mdl_bump = off64;
      g.oc     = OC_SHRINK;
    end else if (cls >= 0 && mdl_count[cls] < LIST_DEPTH) begin
      mdl_slot[cls][mdl_count[cls]] = off;
      mdl_count[cls]++;
      g.oc = OC_LISTED;
    end else begin
      g.oc = OC_DROPPED;
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Send one request item; predict its result once it is accepted
  task automatic send_request(input logic cmd, input logic [23:0] raw, input logic [31:0] off);
    int     gap;
    grant_t g;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= {off, raw};
    in_tuser  <= cmd;
    do @(posedge clk); while (!in_tready);
    g = predict_grant(cmd, raw, off);
    pending_grants.push_back(g);
    last_outcome = g.oc;
    // Track granted blocks so later frees can target them
    if ((g.oc == OC_BUMP || g.oc == OC_REUSE) && raw != 24'd0) begin
      live_blocks.push_back('{base: g.offset, span: ({1'b0, raw} + 25'd15) & ~25'd15});
      if (live_blocks.size() > 64) void'(live_blocks.pop_front());
    end
  endtask

  // Hold the request stream and wait until every result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(input logic [31:0] value);
    drain_results();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    mdl_limit = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Free a tracked block: the newest one half of the time
  task automatic free_live_block();
    int     idx;
    block_t b;
    logic [23:0] raw;
    idx = $urandom_range(0, 1) ? live_blocks.size() - 1 : $urandom_range(0, live_blocks.size() - 1);
    b = live_blocks[idx];
    live_blocks.delete(idx);
    raw = (b.span == 25'd0) ? 24'd0 : 24'(b.span - 25'($urandom_range(0, 15)));
    send_request(CMD_FREE, raw, b.base);
  endtask

  task automatic random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      send_request(CMD_ALLOC, 24'($urandom_range(1, NUM_CLASSES * GRAIN_BYTES)), $urandom);
    end else if (r < 75 && live_blocks.size() > 0) begin
      free_live_block();
    end else if (r < 80) begin
      if ($urandom_range(0, 9) == 0) send_request(CMD_ALLOC, 24'($urandom), $urandom);
      else send_request(CMD_ALLOC, 24'($urandom_range(257, 65536)), $urandom);
    end else if (r < 85) begin
      send_request(1'($urandom), 24'd0, $urandom_range(0, 1) ? mdl_bump[31:0] : $urandom);
    end else begin
      // Noise: any command, size and offset
      send_request(1'($urandom), 24'($urandom), $urandom);
    end
  endtask

  task automatic test_zero_size();
    send_request(CMD_ALLOC, 24'd0, 32'd0);
    send_request(CMD_FREE, 24'd0, mdl_bump[31:0]);
    send_request(CMD_FREE, 24'd0, 32'd0);
    send_request(CMD_ALLOC, 24'd0, 32'hFFFF_FFFF);
  endtask

  task automatic test_class_edges();
    send_request(CMD_ALLOC, 24'd1, 32'd0);
    send_request(CMD_ALLOC, 24'd16, 32'd0);
    send_request(CMD_ALLOC, 24'd17, 32'd0);
    send_request(CMD_ALLOC, 24'd256, 32'd0);
    send_request(CMD_ALLOC, 24'd257, 32'd0);
    // Shrink twice, then list two class-0 blocks and pop them back in LIFO order
    send_request(CMD_FREE, 24'd257, live_blocks[live_blocks.size() - 1].base);
    send_request(CMD_FREE, 24'd256, live_blocks[live_blocks.size() - 2].base);
    send_request(CMD_FREE, 24'd1, live_blocks[0].base);
    send_request(CMD_FREE, 24'd16, live_blocks[1].base);
    send_request(CMD_ALLOC, 24'd5, 32'd0);
    send_request(CMD_ALLOC, 24'd16, 32'd0);
    send_request(CMD_FREE, 24'd257, 32'd5000);
    live_blocks.delete();
  endtask

  task automatic test_list_full();
    for (int i = 0; i < LIST_DEPTH + 1; i++)
      send_request(CMD_FREE, 24'd48, 32'h4000_0000 + 32'(i * 64));
    send_request(CMD_ALLOC, 24'd33, 32'd0);
    send_request(CMD_ALLOC, 24'd48, 32'd0);
  endtask

  task automatic test_large_blocks();
    send_request(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
    send_request(CMD_FREE, 24'hFF_FFFF, live_blocks[live_blocks.size() - 1].base);
    send_request(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
    send_request(CMD_FREE, 24'hFF_FFFF, 32'd0);
  endtask

  task automatic test_heap_limit();
    logic [63:0] gap_bytes;
    // Lowest limit, already below the heap end
    write_limit(32'(CHUNK_BYTES));
    send_request(CMD_ALLOC, 24'hFF_FFFF, 32'd0);
    send_request(CMD_ALLOC, 24'd32, 32'd0);
    send_request(CMD_ALLOC, 24'd0, 32'd0);
    // Limit exactly one chunk above the end: first growth fits, the next fails
    drain_results();
    write_limit(mdl_end[31:0] + 32'(CHUNK_BYTES));
    gap_bytes = mdl_end - mdl_bump;
    send_request(CMD_ALLOC, (gap_bytes > 64'hFF_FFFF) ? 24'hFF_FFFF : gap_bytes[23:0], 32'd0);
    gap_bytes = mdl_end - mdl_bump;
    send_request(CMD_ALLOC, (gap_bytes > 64'hFF_FFFF) ? 24'hFF_FFFF : gap_bytes[23:0], 32'd0);
    write_limit(32'hFFFF_FFFF);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: write_limit(32'hFFFF_FFFF);
        1: write_limit(mdl_end[31:0] + 32'($urandom_range(1, 8) * CHUNK_BYTES));
        2: write_limit(32'(CHUNK_BYTES));
        default: write_limit($urandom_range(CHUNK_BYTES, 32'hFFFF_FFFF));
      endcase
      for (int i = 0; i < 500; i++) begin
        if (i % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_request();
      end
    end
    no_idle = 1'b0;
  endtask

  // Grow the heap until the address space runs out
  task automatic test_address_space();
    int n;
    write_limit(32'hFFFF_FFFF);
    n = 0;
    last_outcome = OC_BUMP;
    while (last_outcome != OC_FAIL && n < 320) begin
      send_request(CMD_ALLOC, 24'hFF_FFFF, $urandom);
      n++;
    end
    send_request(CMD_ALLOC, 24'd16, 32'd0);
    send_request(CMD_ALLOC, 24'd0, 32'd0);
    send_request(CMD_FREE, 24'd32, 32'hFFFF_FFF0);
    free_live_block();
    for (int i = 0; i < 20; i++) random_request();
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_grants.size() == 0) begin
        report_mismatch("result with none pending", 64'(out_tdata), 64'd0);
      end else begin
        seen_grant = pending_grants.pop_front();
        if (out_tdata[31:0] !== seen_grant.offset)
          report_mismatch("alloc_offset", 64'(out_tdata[31:0]), 64'(seen_grant.offset));
        if (out_tdata[34:32] !== seen_grant.oc)
          report_mismatch("outcome", 64'(out_tdata[34:32]), 64'(seen_grant.oc));
      end
    end
  end

  // Random stalls on the result side
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left--;
    end else begin
      out_tready <= 1'b1;
      stall_left = pick_gap();
    end
  end

  // End the run if nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles", QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = '0;
    out_tready   = 1'b0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    no_idle      = 1'b0;
    mdl_bump     = 64'(HEADER_BYTES) & ADDR_MASK;
    mdl_end      = 64'(CHUNK_BYTES);
    mdl_limit    = 32'hFFFF_FFFF;
    for (int c = 0; c < NUM_CLASSES; c++) mdl_count[c] = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_zero_size();
    test_class_edges();
    test_list_full();
    test_large_blocks();
    test_heap_limit();
    test_random();
    test_address_space();

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_grants.size() != 0)
      report_mismatch("results never arrived", 64'(pending_grants.size()), 64'd0);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
